// File: sv/sfc_pkg.sv
// Shared types, character codes and lookup functions of the status line framer.
package sfc_pkg;

  typedef enum logic [3:0] {
    KIND_LRR        = 4'd0,
    KIND_REL_EXP    = 4'd1,
    KIND_RFX        = 4'd2,
    KIND_AUI        = 4'd3,
    KIND_KPM        = 4'd4,
    KIND_KPE        = 4'd5,
    KIND_CRC        = 4'd6,
    KIND_VER        = 4'd7,
    KIND_ERR        = 4'd8,
    KIND_OTHER_BANG = 4'd9,
    KIND_KEYPAD_OK  = 4'd10,
    KIND_KEYPAD_BAD = 4'd11,
    KIND_BAD_PREFIX = 4'd12
  } line_kind_t;

  localparam logic [7:0] CHAR_CR        = 8'h0D;
  localparam logic [7:0] CHAR_LF        = 8'h0A;
  localparam logic [7:0] CHAR_BANG      = 8'h21;
  localparam logic [7:0] CHAR_QUOTE     = 8'h22;
  localparam logic [7:0] CHAR_COMMA     = 8'h2C;
  localparam logic [7:0] CHAR_COLON     = 8'h3A;
  localparam logic [7:0] CHAR_BRACKET   = 8'h5B;
  localparam logic [7:0] PRINT_LOW      = 8'd32;
  localparam logic [7:0] PRINT_HIGH     = 8'd126;

  localparam logic [6:0] LEN_MAX        = 7'd127;
  localparam logic [6:0] LEN_PREFIX     = 7'd5;
  localparam logic [6:0] LEN_KEYPAD     = 7'd94;

  // Ring reads made per finished line, and the line offsets they fetch.
  localparam int unsigned NUM_READS     = 7;
  localparam logic [2:0]  LAST_READ     = 3'(NUM_READS - 1);
  localparam logic [2:0]  IDX_FIRST     = 3'd0;
  localparam logic [2:0]  IDX_TAG0      = 3'd1;
  localparam logic [2:0]  IDX_TAG1      = 3'd2;
  localparam logic [2:0]  IDX_TAG2      = 3'd3;
  localparam logic [2:0]  IDX_COLON     = 3'd4;
  localparam logic [2:0]  IDX_COMMA     = 3'd5;
  localparam logic [2:0]  IDX_QUOTE     = 3'd6;

  typedef struct packed {
    logic [31:0] lost;
    logic [6:0]  length;
  } line_info_t;

  typedef struct packed {
    logic [31:0] lost;
    logic [6:0]  length;
    line_kind_t  kind;
  } line_result_t;

  function automatic logic [6:0] read_offset(input logic [2:0] idx);
    logic [6:0] off;
    case (idx)
      IDX_FIRST: off = 7'd0;
      IDX_TAG0:  off = 7'd1;
      IDX_TAG1:  off = 7'd2;
      IDX_TAG2:  off = 7'd3;
      IDX_COLON: off = 7'd4;
      IDX_COMMA: off = 7'd22;
      IDX_QUOTE: off = 7'd93;
      default:   off = 7'd0;
    endcase
    return off;
  endfunction

  function automatic line_kind_t prefix_kind(input logic [23:0] tag);
    line_kind_t k;
    case (tag)
      "LRR":   k = KIND_LRR;
      "REL":   k = KIND_REL_EXP;
      "EXP":   k = KIND_REL_EXP;
      "RFX":   k = KIND_RFX;
      "AUI":   k = KIND_AUI;
      "KPM":   k = KIND_KPM;
      "KPE":   k = KIND_KPE;
      "CRC":   k = KIND_CRC;
      "VER":   k = KIND_VER;
      "ERR":   k = KIND_ERR;
      default: k = KIND_OTHER_BANG;
    endcase
    return k;
  endfunction

endpackage

// File: sv/status_line_framer_classifier.sv
// Top level of the status line framer and classifier: framing, ring control and result register.
//
// The s_ group takes one received byte per request; the m_ group gives one result per
// finished line (kind, kept length and running lost-byte total). Printable bytes are
// written to the ring; control bytes while scanning are dropped; a control byte other
// than CR or LF inside a line discards it. CR or LF ends a line and hands it to the
// classifier, which makes seven reads on the ring's single read port.
// Throughput: one byte per cycle. A line end holds the classifier until its result is taken;
// a further line end waits until it is free, as does a byte whose ring write would land
// inside the line still being classified. Other bytes keep flowing meanwhile.
// The result reaches m_tvalid after the classifier's read, drain and done states.
// A stalled receiver holds the result register; the classifier then holds its finished
// result, and the framer keeps taking bytes until the next line end.
// Reset clears the ring positions, the line state, the loss counter and both valid
// flags. Ring contents need no clearing, as only bytes written since ever decide a kind.
module status_line_framer_classifier #(
  parameter int unsigned RING_DEPTH = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata    // [3:0] line_kind, [10:4] line_length,
                                 // [42:11] lost_byte_total, [47:43] zero
);
  import sfc_pkg::*;

  localparam int unsigned AW = $clog2(RING_DEPTH);
  localparam logic [AW-1:0] POS_LAST = AW'(RING_DEPTH - 1);
  localparam logic [AW:0]   DEPTH_W  = (AW+1)'(RING_DEPTH);

  logic [AW-1:0] write_pos;
  logic [AW-1:0] read_pos;
  logic          in_line;
  logic [31:0]   lost_count;

  logic [AW-1:0] guard_base;
  logic [AW-1:0] guard_len;

  logic          printable;
  logic          is_eol;
  logic          do_write;
  logic          do_end;
  logic          do_discard;
  logic          clash;
  logic          accept;
  logic [AW:0]   line_len_w;
  logic [AW-1:0] line_len;
  logic [AW:0]   guard_off;
  logic [AW-1:0] wp_next;

  logic          cls_ready;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;
  logic          res_valid;
  logic          res_ready;
  line_result_t  res;
  line_info_t    req_info;
  line_result_t  out_q;

  assign printable  = (s_tdata >= PRINT_LOW) && (s_tdata <= PRINT_HIGH);
  assign is_eol     = (s_tdata == CHAR_CR) || (s_tdata == CHAR_LF);
  assign do_end     = in_line && is_eol;
  assign do_discard = in_line && !printable && !is_eol;
  assign do_write   = printable;

  // While a line is classified its bytes must survive; a write into that span waits.
  always_comb begin
    if (write_pos >= guard_base) begin
      guard_off = {1'b0, write_pos} - {1'b0, guard_base};
    end else begin
      guard_off = {1'b0, write_pos} + DEPTH_W - {1'b0, guard_base};
    end
    clash = !cls_ready && (guard_off < {1'b0, guard_len});
  end

  always_comb begin
    if (write_pos >= read_pos) begin
      line_len_w = {1'b0, write_pos} - {1'b0, read_pos};
    end else begin
      line_len_w = {1'b0, write_pos} + DEPTH_W - {1'b0, read_pos};
    end
    line_len = line_len_w[AW-1:0];
  end

  assign s_tready = !(do_end && !cls_ready) && !(do_write && clash);
  assign accept   = s_tvalid && s_tready;
  assign wp_next  = (write_pos == POS_LAST) ? '0 : write_pos + AW'(1);

  assign req_info.lost   = lost_count;
  assign req_info.length = (line_len > AW'(LEN_MAX)) ? LEN_MAX : line_len[6:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      write_pos  <= '0;
      read_pos   <= '0;
      in_line    <= 1'b0;
      lost_count <= '0;
    end else if (accept) begin
      if (do_end) begin
        read_pos   <= write_pos;
        in_line    <= 1'b0;
        guard_base <= read_pos;
        guard_len  <= line_len;
      end else if (do_discard) begin
        write_pos <= '0;
        read_pos  <= '0;
        in_line   <= 1'b0;
      end else if (do_write) begin
        in_line   <= 1'b1;
        write_pos <= wp_next;
        // A full ring drops its oldest byte.
        if (wp_next == read_pos) begin
          lost_count <= lost_count + 32'd1;
          read_pos   <= (read_pos == POS_LAST) ? '0 : read_pos + AW'(1);
        end
      end
    end
  end

  sfc_ring #(
    .DEPTH (RING_DEPTH),
    .AW    (AW)
  ) u_ring (
    .clk     (clk),
    .wr_en   (accept && do_write),
    .wr_addr (write_pos),
    .wr_data (s_tdata),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  sfc_classifier #(
    .DEPTH (RING_DEPTH),
    .AW    (AW)
  ) u_classifier (
    .clk       (clk),
    .rst       (rst),
    .req_valid (accept && do_end),
    .req_ready (cls_ready),
    .req_base  (read_pos),
    .req_info  (req_info),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
      if (res_valid) begin
        out_q <= res;
      end
    end
  end

  assign m_tdata = {5'b0, out_q.lost, out_q.length, out_q.kind};

endmodule

// File: sv/sfc_ring.sv
// Line ring store: one write port and one registered read port.
module sfc_ring #(
  parameter int unsigned DEPTH = 128,
  parameter int unsigned AW    = 7
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: sv/sfc_classifier.sv
// Line classifier: fetches the prefix and keypad marker bytes from the ring and decides the kind.
module sfc_classifier #(
  parameter int unsigned DEPTH = 128,
  parameter int unsigned AW    = 7
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_ready,
  input  logic [AW-1:0]         req_base,
  input  sfc_pkg::line_info_t   req_info,
  output logic                  rd_en,
  output logic [AW-1:0]         rd_addr,
  input  logic [7:0]            rd_data,
  output logic                  res_valid,
  input  logic                  res_ready,
  output sfc_pkg::line_result_t res
);
  import sfc_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_DRAIN,
    S_DONE
  } state_t;

  localparam logic [AW:0] DEPTH_W = (AW+1)'(DEPTH);

  state_t     state;
  logic [2:0] step;
  logic [2:0] cap_step;
  logic       cap_valid;
  logic [AW-1:0] base;
  line_info_t info;
  logic [7:0] cap_bytes [NUM_READS];
  logic [AW:0] addr_sum;
  line_kind_t kind;

  assign req_ready = (state == S_IDLE);
  assign res_valid = (state == S_DONE);
  assign rd_en     = (state == S_READ);

  // Base and offset are both below the depth, so one subtraction wraps the sum.
  always_comb begin
    addr_sum = {1'b0, base} + (AW+1)'(read_offset(step));
    if (addr_sum >= DEPTH_W) begin
      addr_sum = addr_sum - DEPTH_W;
    end
    rd_addr = addr_sum[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= 3'd0;
      cap_valid <= 1'b0;
    end else begin
      cap_valid <= rd_en;
      cap_step  <= step;
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            base  <= req_base;
            info  <= req_info;
            step  <= 3'd0;
            state <= S_READ;
          end
        end
        S_READ: begin
          if (step == LAST_READ) begin
            state <= S_DRAIN;
          end else begin
            step <= step + 3'd1;
          end
        end
        S_DRAIN: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cap_valid) begin
      cap_bytes[cap_step] <= rd_data;
    end
  end

  always_comb begin
    if (cap_bytes[IDX_FIRST] == CHAR_BANG) begin
      if (info.length >= LEN_PREFIX && cap_bytes[IDX_COLON] == CHAR_COLON) begin
        kind = prefix_kind({cap_bytes[IDX_TAG0], cap_bytes[IDX_TAG1], cap_bytes[IDX_TAG2]});
      end else begin
        kind = KIND_OTHER_BANG;
      end
    end else if (cap_bytes[IDX_FIRST] == CHAR_BRACKET) begin
      if (info.length == LEN_KEYPAD && cap_bytes[IDX_QUOTE] == CHAR_QUOTE &&
          cap_bytes[IDX_COMMA] == CHAR_COMMA) begin
        kind = KIND_KEYPAD_OK;
      end else begin
        kind = KIND_KEYPAD_BAD;
      end
    end else begin
      kind = KIND_BAD_PREFIX;
    end
  end

  assign res.kind   = kind;
  assign res.length = info.length;
  assign res.lost   = info.lost;

endmodule
